// ===== rtl/sntp_tsq_pkg.sv =====
// Shared types and constants of the SNTP time source qualifier.
package sntp_tsq_pkg;

  // Seconds from 1900-01-01 to 1970-01-01
  localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;
  // Mode field value of a server reply
  localparam logic [2:0]  MODE_SERVER     = 3'd4;

  // Configuration register reset values
  localparam logic [7:0] POLL_INTERVAL_RST    = 8'd20;
  localparam logic [7:0] DIFF_THRESHOLD_RST   = 8'd2;
  localparam logic [7:0] STABLE_THRESHOLD_RST = 8'd5;
  localparam logic [8:0] VALID_HOLD_RST       = 9'd40;

  // Item kind carried on tuser
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_REPLY = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_POLL_INTERVAL    = 2'd0,
    REG_DIFF_THRESHOLD   = 2'd1,
    REG_STABLE_THRESHOLD = 2'd2,
    REG_VALID_HOLD       = 2'd3
  } cfg_reg_t;

  // Input tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] local_seconds;
    logic [31:0] server_seconds;
    logic [2:0]  reply_mode;
    logic        allowed;
  } in_item_t;

  // Output tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic        source_valid;
    logic        reply_accepted;
    logic [31:0] new_seconds;
    logic        set_time;
    logic        send_request;
  } out_item_t;

endpackage

// ===== rtl/sntp_time_source_qualifier_core.sv =====
// Top level of the SNTP time source qualifier: tick/reply decision logic.
//
// Usage
//   Input stream (in_*): one item per request. in_tuser is the kind
//   (0 one-second tick, 1 server reply); in_tdata carries the flag that
//   SNTP may act, the reply mode, the server seconds since 1900 and the
//   local Unix seconds.
//   Output stream (out_*): exactly one result per input item, in order:
//   send request pulse, set-time flag with the Unix seconds to load, reply
//   accepted flag and the source-valid status after the item.
//   Configuration port (cfg_*): always ready; writes poll interval, offset
//   threshold, stable threshold and validity hold by index. Write only
//   while the block is idle.
// Timing
//   The result is registered and appears on out_* in the cycle after the input
//   is accepted. One item per cycle is sustained while the receiver takes results:
//   the decision is a single compare and subtract pass feeding the output register.
// Reset and stall
//   rst_n clears the counters and loads the default register values. When
//   the receiver stalls, the result holds in the output register and
//   in_tready drops until it is taken; nothing is lost.
module sntp_time_source_qualifier_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // allowed, reply_mode[2:0], server_seconds[31:0],
                                  // local_seconds[31:0], zero pad[3:0]
  input  logic        in_tuser,   // op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // send_request, set_time, new_seconds[31:0],
                                  // reply_accepted, source_valid, zero pad[3:0]
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  // configuration registers
  logic [7:0] poll_interval_r;
  logic [7:0] diff_threshold_r;
  logic [7:0] stable_threshold_r;
  logic [8:0] valid_hold_r;

  // state
  logic [7:0] poll_count_r,   poll_count_nxt;
  logic [8:0] valid_count_r,  valid_count_nxt;
  logic [7:0] stable_count_r, stable_count_nxt;

  // output register
  logic                   out_valid_r;
  sntp_tsq_pkg::out_item_t out_item_r, out_item_nxt;

  sntp_tsq_pkg::in_item_t in_item;
  sntp_tsq_pkg::op_t      in_op;
  logic                   in_fire;
  logic                   reply_ok;
  logic [31:0]            srv_unix;
  logic [31:0]            diff;
  logic [7:0]             poll_inc;
  logic [7:0]             stable_inc;
  logic                   send_c;
  logic                   set_c;

  assign in_item   = sntp_tsq_pkg::in_item_t'(in_tdata);
  assign in_op     = sntp_tsq_pkg::op_t'(in_tuser);
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_interval_r    <= sntp_tsq_pkg::POLL_INTERVAL_RST;
      diff_threshold_r   <= sntp_tsq_pkg::DIFF_THRESHOLD_RST;
      stable_threshold_r <= sntp_tsq_pkg::STABLE_THRESHOLD_RST;
      valid_hold_r       <= sntp_tsq_pkg::VALID_HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (sntp_tsq_pkg::cfg_reg_t'(cfg_index))
        sntp_tsq_pkg::REG_POLL_INTERVAL:    poll_interval_r    <= cfg_data[7:0];
        sntp_tsq_pkg::REG_DIFF_THRESHOLD:   diff_threshold_r   <= cfg_data[7:0];
        sntp_tsq_pkg::REG_STABLE_THRESHOLD: stable_threshold_r <= cfg_data[7:0];
        sntp_tsq_pkg::REG_VALID_HOLD:       valid_hold_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // reply qualification and offset against local time
  assign reply_ok = in_item.allowed && (in_item.reply_mode == sntp_tsq_pkg::MODE_SERVER)
                    && (in_item.server_seconds > sntp_tsq_pkg::NTP_UNIX_OFFSET);
  assign srv_unix = in_item.server_seconds - sntp_tsq_pkg::NTP_UNIX_OFFSET;
  assign diff     = (srv_unix > in_item.local_seconds) ?
                    (srv_unix - in_item.local_seconds) :
                    (in_item.local_seconds - srv_unix);
  assign poll_inc   = poll_count_r + 8'd1;
  assign stable_inc = stable_count_r + 8'd1;

  // next state and result for the item at the input
  always_comb begin
    poll_count_nxt   = poll_count_r;
    valid_count_nxt  = valid_count_r;
    stable_count_nxt = stable_count_r;
    send_c           = 1'b0;
    set_c            = 1'b0;
    case (in_op)
      sntp_tsq_pkg::OP_TICK: begin
        if (!in_item.allowed) begin
          poll_count_nxt = 8'd0;
        end else begin
          if (valid_count_r != 9'd0) valid_count_nxt = valid_count_r - 9'd1;
          if (poll_inc >= poll_interval_r) begin
            poll_count_nxt = 8'd0;
            send_c         = 1'b1;
          end else begin
            poll_count_nxt = poll_inc;
          end
        end
      end
      sntp_tsq_pkg::OP_REPLY: begin
        if (reply_ok) begin
          if (diff <= {24'd0, diff_threshold_r}) begin
            set_c            = 1'b1;
            stable_count_nxt = 8'd0;
          end else if (stable_inc >= stable_threshold_r) begin
            set_c            = 1'b1;
            stable_count_nxt = 8'd0;
          end else begin
            stable_count_nxt = stable_inc;
          end
          valid_count_nxt = valid_hold_r;
        end
      end
      default: ;
    endcase
    out_item_nxt                = '0;
    out_item_nxt.send_request   = send_c;
    out_item_nxt.set_time       = set_c;
    out_item_nxt.new_seconds    = set_c ? srv_unix : 32'd0;
    out_item_nxt.reply_accepted = (in_op == sntp_tsq_pkg::OP_REPLY) && reply_ok;
    out_item_nxt.source_valid   = (valid_count_nxt != 9'd0);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_count_r   <= 8'd0;
      valid_count_r  <= 9'd0;
      stable_count_r <= 8'd0;
    end else if (in_fire) begin
      poll_count_r   <= poll_count_nxt;
      valid_count_r  <= valid_count_nxt;
      stable_count_r <= stable_count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  // an accepted reply reloads the validity countdown
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && out_item_nxt.reply_accepted |=> valid_count_r == $past(valid_hold_r))
    else $error("validity countdown not reloaded by accepted reply");

  // setting the time restarts the large-offset run
  a_stable_clr: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && set_c |=> stable_count_r == 8'd0)
    else $error("stable count not cleared on time set");

  // a result never carries both a send request and a time set
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.send_request && out_item_r.set_time))
    else $error("send request and set time in one result");

  // new seconds are zero unless the time is set
  a_secs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.set_time |-> out_item_r.new_seconds == 32'd0)
    else $error("new seconds without set time");

  // a stalled result is never overwritten by a new item
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_fire)
    else $error("input accepted over a stalled result");

endmodule
